FILE: sv/mrpt_pkg.sv
// Shared constants, types and state codes for the primality tester.
package mrpt_pkg;

   localparam int NumBits = 32;
   localparam int CntBits = $clog2(NumBits + 1);

   typedef logic [NumBits-1:0] word_type;
   typedef logic [CntBits-1:0] count_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_STRIP,
      ST_REDUCE,
      ST_EXP_SQ,
      ST_EXP_MUL,
      ST_CHECK,
      ST_SQUARE,
      ST_SQ_CHECK,
      ST_DONE
   } state_type;

   // Commands from the sequencer to the modular multiplier
   typedef struct packed {
      logic     start;
      word_type x;
      word_type y;
      word_type m;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      word_type r;
   } mul_rsp_type;

endpackage

FILE: sv/mrpt_mulmod.sv
// Bit-serial modular multiplier: one double-and-add step per cycle.
module mrpt_mulmod (
   input  logic                 clock,
   input  logic                 reset,
   input  mrpt_pkg::mul_req_type req,
   output mrpt_pkg::mul_rsp_type rsp
);
   import mrpt_pkg::*;

   word_type  x_ff, x_in, y_ff, y_in, m_ff, m_in, r_ff, r_in;
   count_type cnt_ff, cnt_in;
   logic      busy_ff, busy_in, done_ff, done_in;

   logic [NumBits:0] dbl, dbl_red, add, add_red;

   // One step: r = 2r mod m, then add x if the top bit of y is set
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      add     = dbl_red + {1'b0, x_ff};
      add_red = (add >= {1'b0, m_ff}) ? add - {1'b0, m_ff} : add;
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; m_in = m_ff; r_in = r_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (req.start) begin
         x_in = req.x; y_in = req.y; m_in = req.m; r_in = '0;
         cnt_in = count_type'(NumBits); busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = y_ff[NumBits-1] ? add_red[NumBits-1:0] : dbl_red[NumBits-1:0];
         y_in   = {y_ff[NumBits-2:0], 1'b0};
         cnt_in = cnt_ff - count_type'(1);
         if (cnt_ff == count_type'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; m_ff <= m_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.r    = r_ff;

   // Done only follows a busy step
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   // Residue stays below modulus once working
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && m_ff != '0 && $past(busy_ff)) |-> r_ff < m_ff)
      else $error("residue out of range");
   // Done is a single pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
endmodule

FILE: sv/miller_rabin_primality_test.sv
// Miller-Rabin round sequencer and handshake top level.
// One beat on req_ runs one witness round for the candidate; a beat with
// req_last_round set also returns the verdict on rsp_. A round for a
// candidate above 4 takes at most (2*bits(d) + s - 1) modular products,
// all from the one bit-serial multiplier; smaller candidates settle
// without it. One round is worked at a time.
module miller_rabin_primality_test (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mrpt_pkg::word_type      req_candidate,
   input  mrpt_pkg::word_type      req_witness,
   input  logic                    req_last_round,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_probable_prime
);
   import mrpt_pkg::*;

   state_type   state_ff, state_in;
   word_type    n_ff, n_in, a_ff, a_in, d_ff, d_in, x_ff, x_in, b_ff, b_in;
   count_type   s_ff, s_in;
   logic        last_ff, last_in, pass_ff, pass_in;
   logic        rvalid_ff, rvalid_in, rbit_ff, rbit_in;
   mul_req_type mreq;
   mul_rsp_type mrsp;
   word_type    nm1;
   logic        round_ok, round_fail;

   mrpt_mulmod u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign nm1 = n_ff - word_type'(1);
   assign req_ready = (state_ff == ST_IDLE) && !rvalid_ff;

   always_comb begin
      state_in = state_ff; n_in = n_ff; a_in = a_ff; d_in = d_ff;
      x_in = x_ff; b_in = b_ff; s_in = s_ff; last_in = last_ff;
      pass_in = pass_ff; rvalid_in = rvalid_ff; rbit_in = rbit_ff;
      mreq = '{start: 1'b0, x: b_ff, y: b_ff, m: n_ff};
      round_ok = 1'b0; round_fail = 1'b0;
      if (rvalid_ff && rsp_ready) rvalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               n_in = req_candidate; a_in = req_witness; last_in = req_last_round;
               state_in = ST_SETUP;
            end
         end
         // Small candidates settle at once
         ST_SETUP: begin
            if (n_ff <= word_type'(1) || n_ff == word_type'(4)) round_fail = 1'b1;
            else if (n_ff <= word_type'(3)) round_ok = 1'b1;
            else begin
               d_in = nm1; s_in = '0; state_in = ST_STRIP;
            end
         end
         // Strip one factor of two a cycle
         ST_STRIP: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[NumBits-1:1]};
               s_in = s_ff + count_type'(1);
            end else begin
               // a mod n via 1*a, the witness shifted in bit by bit
               mreq = '{start: 1'b1, x: word_type'(1), y: a_ff, m: n_ff};
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mrsp.done) begin
               b_in = mrsp.r; x_in = word_type'(1);
               if (d_ff[0]) begin
                  mreq = '{start: 1'b1, x: word_type'(1), y: mrsp.r, m: n_ff};
                  state_in = ST_EXP_MUL;
               end else begin
                  mreq = '{start: 1'b1, x: mrsp.r, y: mrsp.r, m: n_ff};
                  state_in = ST_EXP_SQ;
               end
               x_in = word_type'(1);
            end
         end
         // Right-to-left exponent: multiply then square
         ST_EXP_MUL: begin
            if (mrsp.done) begin
               x_in = mrsp.r;
               d_in = {1'b0, d_ff[NumBits-1:1]};
               if (d_ff[NumBits-1:1] == '0) state_in = ST_CHECK;
               else begin
                  mreq = '{start: 1'b1, x: b_ff, y: b_ff, m: n_ff};
                  state_in = ST_EXP_SQ;
               end
            end
         end
         ST_EXP_SQ: begin
            if (mrsp.done) begin
               b_in = mrsp.r;
               if (d_ff[0]) begin
                  mreq = '{start: 1'b1, x: x_ff, y: mrsp.r, m: n_ff};
                  state_in = ST_EXP_MUL;
               end else begin
                  d_in = {1'b0, d_ff[NumBits-1:1]};
                  mreq = '{start: 1'b1, x: mrsp.r, y: mrsp.r, m: n_ff};
               end
            end
         end
         ST_CHECK: begin
            if (x_ff == word_type'(1) || x_ff == nm1) round_ok = 1'b1;
            else if (s_ff <= count_type'(1)) round_fail = 1'b1;
            else begin
               s_in = s_ff - count_type'(1);
               mreq = '{start: 1'b1, x: x_ff, y: x_ff, m: n_ff};
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mrsp.done) begin
               x_in = mrsp.r; state_in = ST_SQ_CHECK;
            end
         end
         ST_SQ_CHECK: begin
            if (x_ff == word_type'(1)) round_fail = 1'b1;
            else if (x_ff == nm1) round_ok = 1'b1;
            else if (s_ff <= count_type'(1)) round_fail = 1'b1;
            else begin
               s_in = s_ff - count_type'(1);
               mreq = '{start: 1'b1, x: x_ff, y: x_ff, m: n_ff};
               state_in = ST_SQUARE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // Round verdict folds into the sticky flag; a last round sends it and rearms the flag
      if (round_ok || round_fail) begin
         state_in = ST_DONE;
         if (last_ff) begin
            rvalid_in = 1'b1;
            rbit_in   = pass_ff && round_ok;
            pass_in   = 1'b1;
         end else if (round_fail) begin
            pass_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; a_ff <= a_in; d_ff <= d_in; x_ff <= x_in; b_ff <= b_in;
      s_ff <= s_in; last_ff <= last_in; rbit_ff <= rbit_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         pass_ff   <= 1'b1;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pass_ff   <= pass_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_valid             = rvalid_ff;
   assign rsp_is_probable_prime = rbit_ff;

   // No new beat while a verdict waits
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> !req_ready) else $error("accept with verdict pending");
   // Verdict raised only from a finished round
   a_verdict_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> state_ff == ST_DONE) else $error("stray verdict");
   // Flag is back to passing after a verdict
   a_flag_reset: assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> pass_ff) else $error("flag not cleared");
endmodule

FILE: dv/tb_miller_rabin_primality_test.sv
// Self-checking testbench for the Miller-Rabin round sequencer.
`timescale 1ns / 100ps

module tb_miller_rabin_primality_test;
   import mrpt_pkg::*;

   typedef struct {
      logic [31:0] candidate;
      logic [31:0] witness;
      logic        last_round;
   } round_item_type;

   localparam int RoundCycles = 2200;
   localparam longint CycleLimit = 64'd3_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_candidate = '0;
   logic [31:0] req_witness = '0;
   logic        req_last_round = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_probable_prime;

   round_item_type pending_rounds[$];
   logic        expected_verdicts[$];
   bit          verdict_flag = 1'b1;
   int          mismatch_count = 0;
   int          verdicts_seen = 0;
   int          rounds_sent = 0;
   bit          idling_on = 1'b1;
   bit          hold_off = 1'b0;
   longint      cycle_count = 0;
   int          send_gap = 0;
   int          recv_gap = 0;

   miller_rabin_primality_test dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Modular product at full width, double and add
   function automatic logic [31:0] mod_mul(logic [31:0] x, logic [31:0] y, logic [31:0] m);
      logic [32:0] acc;
      acc = '0;
      for (int i = 31; i >= 0; i--) begin
         acc = acc + acc;
         if (acc >= m) acc = acc - m;
         if (y[i]) begin
            acc = acc + x;
            if (acc >= m) acc = acc - m;
         end
      end
      return acc[31:0];
   endfunction

   function automatic bit witness_round_passes(logic [31:0] n, logic [31:0] a);
      logic [31:0] d, x, b, e;
      int s;
      if (n <= 1 || n == 4) return 1'b0;
      if (n <= 3) return 1'b1;
      d = n - 1;
      s = 0;
      while (d[0] == 1'b0) begin
         d = d >> 1;
         s++;
      end
      x = 1;
      b = a % n;
      e = d;
      while (e != 0) begin
         if (e[0]) x = mod_mul(x, b, n);
         b = mod_mul(b, b, n);
         e = e >> 1;
      end
      if (x == 1 || x == n - 1) return 1'b1;
      for (int i = 1; i < s; i++) begin
         x = mod_mul(x, x, n);
         if (x == 1) return 1'b0;
         if (x == n - 1) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Fold one accepted round into the verdict store
   function automatic void predict_round(round_item_type it);
      if (!witness_round_passes(it.candidate, it.witness)) verdict_flag = 1'b0;
      if (it.last_round) begin
         expected_verdicts.push_back(verdict_flag);
         verdict_flag = 1'b1;
      end
   endfunction

   function automatic void queue_round(logic [31:0] n, logic [31:0] a, logic l);
      round_item_type it;
      it.candidate = n;
      it.witness = a;
      it.last_round = l;
      pending_rounds.push_back(it);
   endfunction

   // A candidate with a few random witnesses, last one marked
   function automatic void queue_candidate(logic [31:0] n, int rounds);
      logic [31:0] a;
      for (int r = 0; r < rounds; r++) begin
         a = (n > 4) ? 32'($urandom_range(2, n - 2)) : $urandom;
         queue_round(n, a, r == rounds - 1);
      end
   endfunction

   // Driver: beat held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
      end else begin
         if (req_valid) begin
            round_item_type it;
            it.candidate = req_candidate;
            it.witness = req_witness;
            it.last_round = req_last_round;
            predict_round(it);
            rounds_sent++;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_rounds.size() > 0 && !hold_off) begin
            if (idling_on && $urandom_range(0, 5) == 0) begin
               send_gap <= $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else begin
               round_item_type nx;
               nx = pending_rounds.pop_front();
               req_candidate <= nx.candidate;
               req_witness <= nx.witness;
               req_last_round <= nx.last_round;
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each verdict beat and stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected verdict beat: got %0b", rsp_is_probable_prime);
            end else begin
               logic exp_v;
               exp_v = expected_verdicts.pop_front();
               if (exp_v !== rsp_is_probable_prime) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("verdict mismatch: expected %0b got %0b", exp_v,
                              rsp_is_probable_prime);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            recv_gap <= $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int total;
      logic [31:0] n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: small candidates, extremes, out-of-range witnesses
      queue_round(0, 32'hFFFF_FFFF, 1'b1);
      queue_round(1, 2, 1'b1);
      queue_round(2, 0, 1'b1);
      queue_round(3, 32'hFFFF_FFFF, 1'b1);
      queue_round(4, 3, 1'b1);
      queue_round(5, 2, 1'b1);
      queue_round(32'hFFFF_FFFB, 2, 1'b0);             // largest 32-bit prime
      queue_round(32'hFFFF_FFFB, 32'hFFFF_FFFF, 1'b1); // witness above n
      queue_round(32'hFFFF_FFFF, 3, 1'b1);
      queue_round(6, 4, 1'b1);                         // even above 4
      queue_round(2047, 2, 1'b1);                      // strong pseudoprime to base 2
      queue_round(2047, 3, 1'b1);
      queue_round(561, 2, 1'b1);
      queue_round(7, 14, 1'b1);                        // witness 0 mod n
      queue_round(3, 5, 1'b0);                         // candidate changes mid-verdict
      queue_round(9, 2, 1'b0);
      queue_round(13, 6, 1'b1);
      queue_round(32'h8000_0001, 32'h7FFF_FFFF, 1'b1);
      queue_round(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

      // Pause the sender until every verdict has come back
      wait (pending_rounds.size() == 0 && !req_valid);
      hold_off = 1'b1;
      wait (expected_verdicts.size() == 0);
      repeat (RoundCycles) @(posedge clock);
      hold_off = 1'b0;

      // Random: mostly odd candidates with several witnesses, some noise
      total = 19;
      while (total < 140) begin
         case ($urandom_range(0, 9))
            0: n = $urandom_range(0, 8);
            1: n = $urandom;
            2: n = 32'({8'($urandom_range(0, 255)), 1'b1});
            default: n = $urandom | 32'h1;
         endcase
         if ($urandom_range(0, 7) == 0) begin
            queue_round(n, $urandom, 1'($urandom_range(0, 1)));
            total++;
         end else begin
            int r;
            r = $urandom_range(1, 3);
            queue_candidate(n, r);
            total += r;
         end
         if (total > 110) idling_on = 1'b0;
         wait (pending_rounds.size() < 4);
      end
      queue_round(9, 2, 1'b1); // close any open verdict

      wait (pending_rounds.size() == 0 && !req_valid);
      wait (expected_verdicts.size() == 0);
      repeat (RoundCycles) @(posedge clock);

      $display("Ran %0d witness rounds and checked %0d verdicts, %0d mismatches.",
               rounds_sent, verdicts_seen, mismatch_count);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/mrpt_pkg.sv
sv/mrpt_mulmod.sv
sv/miller_rabin_primality_test.sv
dv/tb_miller_rabin_primality_test.sv
